[rtl/mbc5_pkg.sv]
`timescale 1ns / 1ps
package mbc5_pkg;

  // Field widths
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int TARGET_W    = 3;
  localparam int OFFSET_W    = 23;
  localparam int ROM_SIZE_W  = 10;
  localparam int RAM_SIZE_W  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_VAL_W   = 16;
  localparam int ROM_BANK_W  = 9;
  localparam int RAM_BANK_W  = 2;
  localparam int RAM_LOCAL_W = 13;
  localparam int ROM_LOCAL_W = 14;

  // Controller limits
  localparam int MAX_ROM_BANKS = 512;
  localparam int RAM_BANKS     = 4;

  localparam logic [DATA_W-1:0] ENABLE_KEY = 8'h0A;
  localparam int RAM_BANK_BYTES = 8192;

  // Remainder unit: restoring, several bits per cycle
  localparam int DIV_W          = 16;
  localparam int DIV_BITS_CYCLE = 4;
  localparam int DIV_CYCLES     = DIV_W / DIV_BITS_CYCLE;
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 2'd1;

  typedef enum logic [TARGET_W-1:0] {
    TGT_NONE = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_FF   = 3'd3,
    TGT_REG  = 3'd4
  } target_t;

  typedef enum logic [1:0] {
    OFS_NONE,
    OFS_ADDR,
    OFS_ROM,
    OFS_RAM
  } ofs_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } ctrl_status_t;

endpackage

[rtl/mbc5_if.sv]
`timescale 1ns / 1ps
interface mbc5_bus_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] address;
  logic [7:0]  data;
  modport source (output valid, operation, address, data, input ready);
  modport sink   (input valid, operation, address, data, output ready);
endinterface

interface mbc5_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [22:0] physical_offset;
  logic        ram_write;
  modport source (output valid, target, physical_offset, ram_write, input ready);
  modport sink   (input valid, target, physical_offset, ram_write, output ready);
endinterface

interface mbc5_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] value;
  modport source (output valid, index, value, input ready);
  modport sink   (input valid, index, value, output ready);
endinterface

[rtl/mbc5_bank_mapper_core.sv]
`timescale 1ns / 1ps
// Cartridge bank controller: each bus item (read/write, address, data byte) gives one
// result with its target and byte offset into the ROM or RAM image. Register writes,
// fixed-bank ROM reads, unmapped accesses and disabled RAM reads pass through the
// item latch and the output register, and such items are taken one per cycle while the
// output is drained. Switched-bank ROM reads and RAM accesses pass through the
// shared remainder unit, which retires 4 dividend bits per cycle over a 16-bit
// dividend before the result is loaded. One item is in the remainder unit at a time;
// a finished result waits in the output register while the next item is taken.
// Configuration writes are always accepted and must be made with the block idle.
module mbc5_bank_mapper_core (
  input logic        clk,
  input logic        rst,
  mbc5_cfg_if.sink   cfg,
  mbc5_bus_if.sink   bus,
  mbc5_res_if.source res
);
  import mbc5_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         bus_ready;

  assign cfg.ready = 1'b1;
  assign bus.ready = bus_ready;

  mbc5_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bus.valid),
    .in_ready (bus_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mbc5_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_value     (cfg.value),
    .operation     (bus.operation),
    .address       (bus.address),
    .data          (bus.data),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .out_target    (res.target),
    .out_offset    (res.physical_offset),
    .out_ram_write (res.ram_write)
  );

endmodule

[rtl/mbc5_ctrl.sv]
`timescale 1ns / 1ps
module mbc5_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mbc5_pkg::ctrl_status_t status,
  output mbc5_pkg::ctrl_cmd_t    cmd
);
  import mbc5_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 div_last;

  assign div_last = (cnt == DIV_CNT_W'(DIV_CYCLES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.need_div ? ST_DIV : ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          if (in_valid) begin
            state_next = status.need_div ? ST_DIV : ST_FINISH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        // hand the result over and take the next item in the same cycle
        in_ready   = status.out_free;
        cmd.load   = status.out_free;
        cmd.accept = in_valid & status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/mbc5_dp.sv]
`timescale 1ns / 1ps
module mbc5_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mbc5_pkg::ctrl_cmd_t                 cmd,
  output mbc5_pkg::ctrl_status_t              status,
  input  logic                                cfg_write,
  input  logic [mbc5_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbc5_pkg::CFG_VAL_W-1:0]      cfg_value,
  input  logic                                operation,
  input  logic [mbc5_pkg::ADDR_W-1:0]         address,
  input  logic [mbc5_pkg::DATA_W-1:0]         data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbc5_pkg::TARGET_W-1:0]       out_target,
  output logic [mbc5_pkg::OFFSET_W-1:0]       out_offset,
  output logic                                out_ram_write
);
  import mbc5_pkg::*;

  localparam logic [ROM_SIZE_W-1:0] ROM_MAX = ROM_SIZE_W'(MAX_ROM_BANKS);
  localparam logic [ROM_SIZE_W-1:0] ROM_MIN = ROM_SIZE_W'(2);
  localparam logic [RAM_SIZE_W-1:0] RAM_CLIP = RAM_SIZE_W'(RAM_BANK_BYTES);

  // configuration and controller registers
  logic [ROM_SIZE_W-1:0] rom_size_banks;
  logic [RAM_SIZE_W-1:0] ram_size_bytes;
  logic [DATA_W-1:0]     ram_enable_value;
  logic [7:0]            rom_bank_low;
  logic                  rom_bank_high;
  logic [RAM_BANK_W-1:0] ram_bank;

  // latched item
  target_t            lat_target;
  ofs_kind_t          lat_kind;
  logic               lat_ram_write;
  logic [ADDR_W-1:0]  lat_addr;
  logic [DIV_W-1:0]   divisor;
  logic [DIV_W-1:0]   dividend;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dividend_next;
  logic [DIV_W-1:0]   rem_next;

  // decode of the incoming item
  target_t              dec_target;
  ofs_kind_t            dec_kind;
  logic                 dec_ram_write;
  logic                 dec_div;
  logic [DIV_W-1:0]     dec_dividend;
  logic [DIV_W-1:0]     dec_divisor;
  logic [ROM_SIZE_W-1:0] rom_n;
  logic [ROM_BANK_W-1:0] bank_eff;
  logic [RAM_SIZE_W-1:0] ram_clip;
  logic [RAM_LOCAL_W:0]  ram_win;
  logic [RAM_LOCAL_W-1:0] local_addr;
  logic                  reg_write;

  // output register
  target_t              res_target;
  logic [OFFSET_W-1:0]  res_offset;
  logic                 res_ram_write;
  logic [OFFSET_W-1:0]  offset_calc;

  always_comb begin
    if (rom_size_banks < ROM_MIN) begin
      rom_n = ROM_MIN;
    end else if (rom_size_banks > ROM_MAX) begin
      rom_n = ROM_MAX;
    end else begin
      rom_n = rom_size_banks;
    end
  end

  assign bank_eff   = ({rom_bank_high, rom_bank_low} == '0) ? ROM_BANK_W'(1)
                                                            : {rom_bank_high, rom_bank_low};
  assign ram_clip   = (ram_size_bytes > RAM_CLIP) ? RAM_CLIP : ram_size_bytes;
  assign ram_win    = {ram_clip[RAM_LOCAL_W:8], 8'h00};
  assign local_addr = address[RAM_LOCAL_W-1:0];

  always_comb begin
    dec_target    = TGT_NONE;
    dec_kind      = OFS_NONE;
    dec_ram_write = 1'b0;
    dec_div       = 1'b0;
    dec_dividend  = '0;
    dec_divisor   = DIV_W'(rom_n);
    if (!address[15]) begin
      if (operation) begin
        dec_target = TGT_REG;
      end else if (!address[14]) begin
        dec_target = TGT_ROM;
        dec_kind   = OFS_ADDR;
      end else begin
        dec_target   = TGT_ROM;
        dec_kind     = OFS_ROM;
        dec_div      = 1'b1;
        dec_dividend = DIV_W'(bank_eff);
      end
    end else if (address[15:13] == 3'b101) begin
      if ({1'b0, local_addr} < ram_win) begin
        if (operation || (ram_enable_value == ENABLE_KEY)) begin
          dec_target    = TGT_RAM;
          dec_kind      = OFS_RAM;
          dec_ram_write = operation;
          dec_div       = 1'b1;
          dec_dividend  = DIV_W'({ram_bank, local_addr});
          dec_divisor   = ram_size_bytes;
        end else begin
          dec_target = TGT_FF;
        end
      end else begin
        dec_target = operation ? TGT_REG : TGT_FF;
      end
    end
  end

  assign status.need_div = dec_div;
  assign status.out_free = !out_valid || out_ready;
  assign reg_write       = cmd.accept && operation && !address[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_banks   <= ROM_SIZE_W'(2);
      ram_size_bytes   <= '0;
      ram_enable_value <= '0;
      rom_bank_low     <= 8'h01;
      rom_bank_high    <= 1'b0;
      ram_bank         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_ROM_SIZE: rom_size_banks <= cfg_value[ROM_SIZE_W-1:0];
          CFG_RAM_SIZE: ram_size_bytes <= cfg_value[RAM_SIZE_W-1:0];
          default: ;
        endcase
      end
      if (reg_write) begin
        case (address[14:12])
          3'b000, 3'b001: ram_enable_value <= data;
          3'b010:         rom_bank_low     <= data;
          3'b011:         rom_bank_high    <= data[0];
          3'b100, 3'b101: begin
            if (data < DATA_W'(RAM_BANKS)) begin
              ram_bank <= data[RAM_BANK_W-1:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  // restoring remainder, DIV_BITS_CYCLE dividend bits per cycle
  always_comb begin
    logic [DIV_W:0]   r;
    logic [DIV_W-1:0] q;
    r = {1'b0, rem};
    q = dividend;
    for (int i = 0; i < DIV_BITS_CYCLE; i++) begin
      r = {r[DIV_W-1:0], q[DIV_W-1]};
      q = {q[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
      end
    end
    rem_next      = r[DIV_W-1:0];
    dividend_next = q;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lat_target    <= dec_target;
      lat_kind      <= dec_kind;
      lat_ram_write <= dec_ram_write;
      lat_addr      <= address;
      divisor       <= dec_divisor;
      dividend      <= dec_dividend;
      rem           <= '0;
    end else if (cmd.div_step) begin
      dividend <= dividend_next;
      rem      <= rem_next;
    end
  end

  always_comb begin
    case (lat_kind)
      OFS_ADDR: offset_calc = OFFSET_W'(lat_addr);
      OFS_ROM:  offset_calc = {rem[ROM_BANK_W-1:0], lat_addr[ROM_LOCAL_W-1:0]};
      OFS_RAM:  offset_calc = OFFSET_W'(rem);
      default:  offset_calc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_target    <= lat_target;
      res_offset    <= offset_calc;
      res_ram_write <= lat_ram_write;
    end
  end

  assign out_target    = res_target;
  assign out_offset    = res_offset;
  assign out_ram_write = res_ram_write;

endmodule

[rtl/mbc5_checker.sv]
`timescale 1ns / 1ps
module mbc5_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  res_target,
  input logic [22:0] res_offset,
  input logic        res_ram_write
);
  import mbc5_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_target)
      && $stable(res_offset) && $stable(res_ram_write))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_target != TGT_ROM) && (res_target != TGT_RAM) |-> res_offset == '0)
    else $error("offset set for a target without image");

  a_write_ram: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ram_write |-> res_target == TGT_RAM)
    else $error("RAM write flagged outside RAM target");

endmodule

bind mbc5_bank_mapper_core mbc5_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_target    (res.target),
  .res_offset    (res.physical_offset),
  .res_ram_write (res.ram_write)
);

[dv/tb_mbc5_bank_mapper_core.sv]
`timescale 1ns / 1ps
module tb_mbc5_bank_mapper_core;
  import mbc5_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SEGMENTS        = 12;
  localparam int ITEMS_PER_SEG   = 125;

  typedef struct {
    logic        wr;
    logic [15:0] addr;
    target_t     target;
    logic [22:0] offset;
    logic        ram_write;
  } bus_map_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mbc5_cfg_if cfg_if ();
  mbc5_bus_if bus_if ();
  mbc5_res_if res_if ();

  mbc5_bank_mapper_core uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_if),
    .bus (bus_if),
    .res (res_if)
  );

  // Controller state as seen by the mapping predictor
  logic [ROM_SIZE_W-1:0] rom_banks_cfg = 10'd2;
  logic [RAM_SIZE_W-1:0] ram_bytes_cfg = 16'd0;
  logic [7:0]            ram_enable_q  = 8'h00;
  logic [7:0]            rom_bank_lo_q = 8'h01;
  logic                  rom_bank_hi_q = 1'b0;
  logic [1:0]            ram_bank_q    = 2'd0;

  bus_map_t pending_maps[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mbc5_bank_mapper_core test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  // Apply one bus access to the predicted controller state and return its mapping
  function automatic bus_map_t map_access(input logic wr, input logic [15:0] addr,
                                          input logic [7:0] d);
    bus_map_t    m;
    int unsigned bank;
    int unsigned fitted;
    int unsigned window;
    int unsigned ram_local;
    m.wr        = wr;
    m.addr      = addr;
    m.target    = TGT_NONE;
    m.offset    = '0;
    m.ram_write = 1'b0;
    if (addr < 16'h8000) begin
      if (wr) begin
        m.target = TGT_REG;
        if (addr < 16'h2000) begin
          ram_enable_q = d;
        end else if (addr < 16'h3000) begin
          rom_bank_lo_q = d;
        end else if (addr < 16'h4000) begin
          rom_bank_hi_q = d[0];
        end else if (addr < 16'h6000) begin
          if (d < RAM_BANKS) ram_bank_q = d[1:0];
        end
      end else if (addr < 16'h4000) begin
        m.target = TGT_ROM;
        m.offset = 23'(addr);
      end else begin
        bank = 32'({rom_bank_hi_q, rom_bank_lo_q});
        if (bank == 0) bank = 1;
        fitted = 32'(rom_banks_cfg);
        if (fitted < 2) fitted = 2;
        if (fitted > MAX_ROM_BANKS) fitted = MAX_ROM_BANKS;
        m.target = TGT_ROM;
        m.offset = 23'((bank % fitted) * 16384 + (32'(addr) - 32'h4000));
      end
    end else if (addr >= 16'hA000 && addr < 16'hC000) begin
      ram_local = 32'(addr) - 32'hA000;
      window = (ram_bytes_cfg > RAM_BANK_BYTES) ? RAM_BANK_BYTES : 32'(ram_bytes_cfg);
      window = window & ~32'hFF;
      if (ram_local < window) begin
        if (wr || ram_enable_q == ENABLE_KEY) begin
          m.target    = TGT_RAM;
          m.offset    = 23'((ram_bank_q * RAM_BANK_BYTES + ram_local) % ram_bytes_cfg);
          m.ram_write = wr;
        end else begin
          m.target = TGT_FF;
        end
      end else begin
        m.target = wr ? TGT_REG : TGT_FF;
      end
    end
    return m;
  endfunction

  always @(posedge clk) begin : check_results
    bus_map_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (pending_maps.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: target %0d offset %0h",
                                  res_if.target, res_if.physical_offset));
      end else begin
        want = pending_maps.pop_front();
        if (res_if.target !== want.target)
          report_mismatch($sformatf("wr %0b addr %h: target %0d, want %0d",
                                    want.wr, want.addr, res_if.target, want.target));
        if (res_if.physical_offset !== want.offset)
          report_mismatch($sformatf("wr %0b addr %h: offset %h, want %h",
                                    want.wr, want.addr, res_if.physical_offset, want.offset));
        if (res_if.ram_write !== want.ram_write)
          report_mismatch($sformatf("wr %0b addr %h: ram_write %0b, want %0b",
                                    want.wr, want.addr, res_if.ram_write, want.ram_write));
      end
    end
  end

  // Returns at the accepting edge with valid still high; the caller decides the next step
  task automatic send_access(input logic wr, input logic [15:0] addr, input logic [7:0] d);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      bus_if.valid <= 1'b0;
      @(negedge clk);
    end
    bus_if.valid     <= 1'b1;
    bus_if.operation <= wr;
    bus_if.address   <= addr;
    bus_if.data      <= d;
    do @(posedge clk); while (!bus_if.ready);
    pending_maps.push_back(map_access(wr, addr, d));
  endtask

  // Hold off new items until every pending result has come back
  task automatic settle();
    @(negedge clk);
    bus_if.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_VAL_W-1:0] val);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.value <= val;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == CFG_ROM_SIZE) begin
      rom_banks_cfg = val[ROM_SIZE_W-1:0];
    end else if (idx == CFG_RAM_SIZE) begin
      ram_bytes_cfg = val;
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'hFF);
  endtask

  task automatic test_register_map();
    write_reg(CFG_ROM_SIZE, 16'd512);
    write_reg(CFG_RAM_SIZE, 16'd32768);
    send_access(OP_READ,  16'h3FFF, 8'h00);
    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h2FFF, 8'hFF);
    send_access(OP_WRITE, 16'h3000, 8'h01);
    send_access(OP_READ,  16'h5555, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFE);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h0000, ENABLE_KEY);
    send_access(OP_WRITE, 16'hBFFF, 8'hAB);
    send_access(OP_WRITE, 16'h4000, 8'h03);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    // RAM bank select at or above RAM_BANKS must not stick
    send_access(OP_WRITE, 16'h5FFF, 8'h04);
    send_access(OP_WRITE, 16'h7FFF, 8'h55);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_WRITE, 16'h9FFF, 8'h5A);
    send_access(OP_READ,  16'hC000, 8'h00);
    send_access(OP_WRITE, 16'hFFFF, 8'hFF);
    send_access(OP_WRITE, 16'h1FFF, 8'h0B);
    send_access(OP_READ,  16'hA123, 8'h00);
  endtask

  task automatic test_size_extremes();
    write_reg(CFG_ROM_SIZE, 16'd1);
    write_reg(CFG_RAM_SIZE, 16'd2048);
    send_access(OP_WRITE, 16'h2000, 8'h03);
    send_access(OP_READ,  16'h4001, 8'h00);
    send_access(OP_WRITE, 16'hA7FF, 8'h11);
    send_access(OP_WRITE, 16'hA800, 8'h22);
    send_access(OP_READ,  16'hA800, 8'h00);
    write_reg(CFG_ROM_SIZE, 16'd1023);
    write_reg(CFG_RAM_SIZE, 16'd255);
    send_access(OP_READ,  16'h7000, 8'h00);
    send_access(OP_WRITE, 16'hA000, 8'h33);
  endtask

  task automatic send_traffic_item();
    int unsigned pick;
    int unsigned span;
    logic        wr;
    logic [15:0] a;
    logic [7:0]  d;
    pick = $urandom_range(0, 99);
    wr   = 1'($urandom_range(0, 1));
    a    = 16'($urandom_range(0, 16'hFFFF));
    d    = 8'($urandom_range(0, 255));
    if (pick < 30) begin
      wr = OP_READ;
      a  = 16'($urandom_range(0, 16'h7FFF));
    end else if (pick < 45) begin
      wr = OP_WRITE;
      a  = 16'($urandom_range(16'h2000, 16'h3FFF));
    end else if (pick < 55) begin
      wr = OP_WRITE;
      a  = 16'($urandom_range(0, 16'h1FFF));
      if ($urandom_range(0, 9) < 6) d = ENABLE_KEY;
    end else if (pick < 65) begin
      wr = OP_WRITE;
      a  = 16'($urandom_range(16'h4000, 16'h5FFF));
      if ($urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 7));
    end else if (pick < 90) begin
      // bias toward the low end so small RAM windows still get hits
      case ($urandom_range(0, 2))
        0:       span = 255;
        1:       span = 2047;
        default: span = 8191;
      endcase
      a = 16'hA000 + 16'($urandom_range(0, span));
    end
    send_access(wr, a, d);
  endtask

  task automatic test_random_traffic();
    logic [ROM_SIZE_W-1:0] rom_size;
    logic [RAM_SIZE_W-1:0] ram_size;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       begin rom_size = 10'd2;    ram_size = 16'd8192;  end
        1:       begin rom_size = 10'd512;  ram_size = 16'd32768; end
        2:       begin rom_size = 10'd0;    ram_size = 16'd2048;  end
        3:       begin rom_size = 10'd37;   ram_size = 16'd300;   end
        4:       begin rom_size = 10'd1023; ram_size = 16'd0;     end
        5:       begin rom_size = 10'd3;    ram_size = 16'd65535; end
        6:       begin rom_size = 10'd256;  ram_size = 16'd5000;  end
        7:       begin rom_size = 10'd1;    ram_size = 16'd32768; end
        8:       begin rom_size = 10'd513;  ram_size = 16'd255;   end
        9:       begin rom_size = 10'd100;  ram_size = 16'd40000; end
        10:      begin rom_size = 10'd64;   ram_size = 16'd2048;  end
        default: begin rom_size = 10'd511;  ram_size = 16'd8192;  end
      endcase
      write_reg(CFG_ROM_SIZE, 16'(rom_size));
      write_reg(CFG_RAM_SIZE, ram_size);
      if (seg < 4) begin
        send_idle_pct = 31;
        recv_idle_pct = 69;
      end else if (seg < 8) begin
        send_idle_pct = 69;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < ITEMS_PER_SEG; i++) begin
        // drain the pipe once mid-segment
        if (i == ITEMS_PER_SEG / 2) settle();
        send_traffic_item();
      end
    end
  endtask

  initial begin
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_ROM_SIZE;
    cfg_if.value     = '0;
    bus_if.valid     = 1'b0;
    bus_if.operation = OP_READ;
    bus_if.address   = '0;
    bus_if.data      = '0;
    res_if.ready     = 1'b0;
    send_idle_pct    = 31;
    recv_idle_pct    = 69;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_register_map();
    test_size_extremes();
    test_random_traffic();

    settle();
    if (error_count == 0) begin
      $display("mbc5_bank_mapper_core test passed");
    end else begin
      $display("mbc5_bank_mapper_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mbc5_pkg.sv
rtl/mbc5_if.sv
rtl/mbc5_ctrl.sv
rtl/mbc5_dp.sv
rtl/mbc5_bank_mapper_core.sv
rtl/mbc5_checker.sv
dv/tb_mbc5_bank_mapper_core.sv
